>>> hw/rtl/gia_pkg.sv
package gia_pkg;

  // field widths
  localparam int AXIS_W      = 16;
  localparam int CFG_W       = 15;
  localparam int COUNT_W     = 7;
  localparam int CFG_ADDR_W  = 2;

  // squarer digit size and steps over one axis magnitude
  localparam int DIGIT_W     = 4;
  localparam int SQ_STEPS    = AXIS_W / DIGIT_W;

  // lanes: three accelerometer axes, three gyro axes
  localparam int VEC_AXES    = 3;
  localparam int NUM_AXES    = 2 * VEC_AXES;

  localparam int SENSORS_DEF = 64;
  localparam int COUNT_LIMIT = 127;

  localparam logic [CFG_W-1:0] ACC_MIN_RST  = 15'd2048;
  localparam logic [CFG_W-1:0] ACC_MAX_RST  = 15'd8192;
  localparam logic [CFG_W-1:0] RATE_MAX_RST = 15'd160;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ACC_MIN  = 2'd0,
    CFG_ACC_MAX  = 2'd1,
    CFG_RATE_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_CHK,
    ST_LAST,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/gia_if.sv
interface gia_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gia_pkg::AXIS_W-1:0] acc_x;
  logic signed [gia_pkg::AXIS_W-1:0] acc_y;
  logic signed [gia_pkg::AXIS_W-1:0] acc_z;
  logic signed [gia_pkg::AXIS_W-1:0] rate_x;
  logic signed [gia_pkg::AXIS_W-1:0] rate_y;
  logic signed [gia_pkg::AXIS_W-1:0] rate_z;
  logic                               last_sensor;

  modport source (
    output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, last_sensor,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, last_sensor,
    output ready
  );
endinterface

interface gia_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gia_pkg::AXIS_W-1:0] mean_acc_x;
  logic signed [gia_pkg::AXIS_W-1:0] mean_acc_y;
  logic signed [gia_pkg::AXIS_W-1:0] mean_acc_z;
  logic signed [gia_pkg::AXIS_W-1:0] mean_rate_x;
  logic signed [gia_pkg::AXIS_W-1:0] mean_rate_y;
  logic signed [gia_pkg::AXIS_W-1:0] mean_rate_z;
  logic        [gia_pkg::COUNT_W-1:0] valid_count;

  modport source (
    output valid, mean_acc_x, mean_acc_y, mean_acc_z,
           mean_rate_x, mean_rate_y, mean_rate_z, valid_count,
    input  ready
  );
  modport sink (
    input  valid, mean_acc_x, mean_acc_y, mean_acc_z,
           mean_rate_x, mean_rate_y, mean_rate_z, valid_count,
    output ready
  );
endinterface

>>> hw/rtl/gia_sqr.sv
// digit-serial sum of squares, one multiplier digit per step, msb digit first
module gia_sqr #(
  parameter int N = 1
) (
  input  logic                                        clk,
  input  logic                                        load,
  input  logic                                        step,
  input  logic [gia_pkg::AXIS_W-1:0]                  val [N],
  output logic [2*gia_pkg::AXIS_W+$clog2(N)-1:0]      sum
);

  localparam int VAL_W  = gia_pkg::AXIS_W;
  localparam int DIG_W  = gia_pkg::DIGIT_W;
  localparam int SQ_W   = 2 * VAL_W + $clog2(N);
  localparam int PROD_W = VAL_W + DIG_W;

  logic [VAL_W-1:0]  mcand  [N];
  logic [VAL_W-1:0]  mplier [N];
  logic [SQ_W-1:0]   acc;
  logic [SQ_W-1:0]   acc_next;
  logic [PROD_W-1:0] prod   [N];
  logic [SQ_W-1:0]   psum;

  always_comb begin
    psum = '0;
    for (int i = 0; i < N; i++) begin
      prod[i] = PROD_W'(mcand[i]) * PROD_W'(mplier[i][VAL_W-1 -: DIG_W]);
      psum    = psum + SQ_W'(prod[i]);
    end
    acc_next = {acc[SQ_W-DIG_W-1:0], {DIG_W{1'b0}}} + psum;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < N; i++) begin
        mcand[i]  <= val[i];
        mplier[i] <= val[i];
      end
      acc <= '0;
    end else if (step) begin
      for (int i = 0; i < N; i++) begin
        mplier[i] <= {mplier[i][VAL_W-DIG_W-1:0], {DIG_W{1'b0}}};
      end
      acc <= acc_next;
    end
  end

  assign sum = acc;

endmodule

>>> hw/rtl/gia_div.sv
// bit-serial restoring divide, all lanes share one divisor and one counter
module gia_div #(
  parameter int SUM_W = 22,
  parameter int CNT_W = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [SUM_W-1:0]           dividend [gia_pkg::NUM_AXES],
  input  logic        [CNT_W-1:0]           divisor,
  output logic                              busy,
  output logic signed [gia_pkg::AXIS_W-1:0] quo      [gia_pkg::NUM_AXES]
);

  localparam int LANES = gia_pkg::NUM_AXES;
  localparam int OUT_W = gia_pkg::AXIS_W;
  localparam int IDX_W = $clog2(SUM_W);

  logic [IDX_W-1:0]   cnt;
  logic [CNT_W-1:0]   dvs;
  logic               neg       [LANES];
  logic [SUM_W-1:0]   work      [LANES];
  logic [CNT_W-1:0]   rem       [LANES];
  logic [SUM_W-1:0]   work_next [LANES];
  logic [CNT_W-1:0]   rem_next  [LANES];
  logic [CNT_W:0]     trial     [LANES];
  logic               fits      [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i]     = {rem[i], work[i][SUM_W-1]};
      fits[i]      = trial[i] >= {1'b0, dvs};
      rem_next[i]  = fits[i] ? CNT_W'(trial[i] - {1'b0, dvs}) : CNT_W'(trial[i]);
      work_next[i] = {work[i][SUM_W-2:0], fits[i]};
      quo[i]       = neg[i] ? $signed(~work[i][OUT_W-1:0] + OUT_W'(1))
                            : $signed(work[i][OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + IDX_W'(1);
      if (cnt == IDX_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // magnitudes go in, sign is put back on the low bits at the end
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int i = 0; i < LANES; i++) begin
        neg[i]  <= dividend[i][SUM_W-1];
        work[i] <= dividend[i][SUM_W-1] ? (~dividend[i] + SUM_W'(1)) : dividend[i];
        rem[i]  <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < LANES; i++) begin
        work[i] <= work_next[i];
        rem[i]  <= rem_next[i];
      end
    end
  end

endmodule

>>> hw/rtl/gated_imu_array_average.sv
// channel   dir  transfer when        payload
// in_ch     in   valid & ready        acc_x/y/z, rate_x/y/z, last_sensor
// out_ch    out  valid & ready        mean_acc_x/y/z, mean_rate_x/y/z, valid_count
// cfg       in   cfg_we               cfg_addr, cfg_wdata (no handshake)
//
// a reading takes 4 digit steps of the squarers (ST_SQR) over the 16-bit
//   magnitudes, then the gate/accumulate state ST_CHK, which after a non-last reading also takes the next
// a last reading goes on from ST_CHK to ST_LAST, then through the divider (ST_DIV)
//   to ST_OUT, which loads its result; ST_DIV is skipped when no reading passed
//   the gate; the next reading is taken in idle once that result is loaded
// reset (sync) loads the default bounds, clears sums, count and output valid
// the result waits in the output register; readings keep coming in meanwhile,
//   only the next last reading holds until that result is taken
module gated_imu_array_average #(
  parameter int SENSORS = gia_pkg::SENSORS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gia_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gia_pkg::CFG_W-1:0]         cfg_wdata,
  gia_in_if.sink                            in_ch,
  gia_out_if.source                         out_ch
);

  localparam int AXIS_W  = gia_pkg::AXIS_W;
  localparam int CFG_W   = gia_pkg::CFG_W;
  localparam int COUNT_W = gia_pkg::COUNT_W;
  localparam int VEC     = gia_pkg::VEC_AXES;
  localparam int LANES   = gia_pkg::NUM_AXES;
  localparam int STEPS   = gia_pkg::SQ_STEPS;
  // valid readings stop counting at this cap until the result is loaded into the output reg
  localparam int CAP     = (SENSORS < gia_pkg::COUNT_LIMIT) ? SENSORS
                                                            : gia_pkg::COUNT_LIMIT;
  localparam int CNT_W   = $clog2(CAP + 1);
  localparam int SUM_W   = AXIS_W + $clog2(CAP);
  localparam int NRM_W   = 2 * AXIS_W + $clog2(VEC);
  localparam int THR_W   = 2 * AXIS_W;
  localparam int STEP_W  = $clog2(STEPS);

  // bound registers
  logic [CFG_W-1:0] cfg_acc_min;
  logic [CFG_W-1:0] cfg_acc_max;
  logic [CFG_W-1:0] cfg_rate_max;

  // control
  gia_pkg::state_t   state;
  gia_pkg::state_t   state_next;
  logic [STEP_W-1:0] step_cnt;
  logic              last_q;
  logic              in_rdy;
  logic              in_fire;
  logic              sq_step;
  logic              div_start;
  logic              div_busy;
  logic              load_out;
  logic              pass;

  // held reading and accumulators
  logic signed [AXIS_W-1:0] axis_q    [LANES];
  logic signed [SUM_W-1:0]  sums      [LANES];
  logic        [CNT_W-1:0]  good_count;

  // input axes and magnitudes
  logic signed [AXIS_W-1:0] in_axis   [LANES];
  logic        [AXIS_W-1:0] mag_acc   [VEC];
  logic        [AXIS_W-1:0] mag_rate  [VEC];

  // bounds widened for the squarers
  logic [AXIS_W-1:0] thr_amin [1];
  logic [AXIS_W-1:0] thr_amax [1];
  logic [AXIS_W-1:0] thr_gmax [1];

  logic [NRM_W-1:0] acc_norm;
  logic [NRM_W-1:0] rate_norm;
  logic [THR_W-1:0] amin_sq;
  logic [THR_W-1:0] amax_sq;
  logic [THR_W-1:0] gmax_sq;

  logic signed [AXIS_W-1:0] div_quo [LANES];

  // output register
  logic                     out_valid;
  logic signed [AXIS_W-1:0] mean_q  [LANES];
  logic        [COUNT_W-1:0] count_q;

  assign in_axis[0] = in_ch.acc_x;
  assign in_axis[1] = in_ch.acc_y;
  assign in_axis[2] = in_ch.acc_z;
  assign in_axis[3] = in_ch.rate_x;
  assign in_axis[4] = in_ch.rate_y;
  assign in_axis[5] = in_ch.rate_z;

  // absolute values, -32768 maps to 32768 which still fits unsigned
  always_comb begin
    for (int i = 0; i < VEC; i++) begin
      mag_acc[i]  = in_axis[i][AXIS_W-1] ? (~in_axis[i] + AXIS_W'(1)) : in_axis[i];
      mag_rate[i] = in_axis[VEC+i][AXIS_W-1] ? (~in_axis[VEC+i] + AXIS_W'(1))
                                               : in_axis[VEC+i];
    end
  end

  assign thr_amin[0] = AXIS_W'(cfg_acc_min);
  assign thr_amax[0] = AXIS_W'(cfg_acc_max);
  assign thr_gmax[0] = AXIS_W'(cfg_rate_max);

  assign in_fire = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;
  assign sq_step = (state == gia_pkg::ST_SQR);

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_acc_min  <= gia_pkg::ACC_MIN_RST;
      cfg_acc_max  <= gia_pkg::ACC_MAX_RST;
      cfg_rate_max <= gia_pkg::RATE_MAX_RST;
    end else if (cfg_we) begin
      unique case (gia_pkg::cfg_idx_t'(cfg_addr))
        gia_pkg::CFG_ACC_MIN:  cfg_acc_min  <= cfg_wdata;
        gia_pkg::CFG_ACC_MAX:  cfg_acc_max  <= cfg_wdata;
        gia_pkg::CFG_RATE_MAX: cfg_rate_max <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // squared norms and squared bounds, all lanes step together
  gia_sqr #(.N(VEC)) u_sqr_acc (
    .clk (clk), .load (in_fire), .step (sq_step), .val (mag_acc), .sum (acc_norm)
  );
  gia_sqr #(.N(VEC)) u_sqr_rate (
    .clk (clk), .load (in_fire), .step (sq_step), .val (mag_rate), .sum (rate_norm)
  );
  gia_sqr #(.N(1)) u_sqr_amin (
    .clk (clk), .load (in_fire), .step (sq_step), .val (thr_amin), .sum (amin_sq)
  );
  gia_sqr #(.N(1)) u_sqr_amax (
    .clk (clk), .load (in_fire), .step (sq_step), .val (thr_amax), .sum (amax_sq)
  );
  gia_sqr #(.N(1)) u_sqr_gmax (
    .clk (clk), .load (in_fire), .step (sq_step), .val (thr_gmax), .sum (gmax_sq)
  );

  // gate: strict bounds on both norms, and room left in the count
  assign pass = (acc_norm > NRM_W'(amin_sq)) &&
                (acc_norm < NRM_W'(amax_sq)) &&
                (rate_norm < NRM_W'(gmax_sq)) &&
                (good_count < CNT_W'(CAP));

  // averages of the closed snapshot
  gia_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums),
    .divisor  (good_count),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gia_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_rdy     = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      gia_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) state_next = gia_pkg::ST_SQR;
      end
      gia_pkg::ST_SQR: begin
        if (step_cnt == STEP_W'(STEPS - 1)) state_next = gia_pkg::ST_CHK;
      end
      gia_pkg::ST_CHK: begin
        // accumulate now; a non-last reading lets the next one in this cycle
        if (last_q) begin
          state_next = gia_pkg::ST_LAST;
        end else begin
          in_rdy = 1'b1;
          state_next = in_ch.valid ? gia_pkg::ST_SQR : gia_pkg::ST_IDLE;
        end
      end
      gia_pkg::ST_LAST: begin
        if (good_count == '0) begin
          state_next = gia_pkg::ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = gia_pkg::ST_DIV;
        end
      end
      gia_pkg::ST_DIV: begin
        if (!div_busy) state_next = gia_pkg::ST_OUT;
      end
      gia_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ch.ready) begin
          load_out   = 1'b1;
          state_next = gia_pkg::ST_IDLE;
        end
      end
      default: state_next = gia_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_cnt <= '0;
      last_q   <= in_ch.last_sensor;
      for (int i = 0; i < LANES; i++) begin
        axis_q[i] <= in_axis[i];
      end
    end else if (sq_step) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  // running sums and count, cleared once the result is taken into the output reg
  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      good_count <= '0;
      for (int i = 0; i < LANES; i++) begin
        sums[i] <= '0;
      end
    end else if (state == gia_pkg::ST_CHK && pass) begin
      good_count <= good_count + CNT_W'(1);
      for (int i = 0; i < LANES; i++) begin
        sums[i] <= sums[i] + SUM_W'(axis_q[i]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      count_q <= COUNT_W'(good_count);
      for (int i = 0; i < LANES; i++) begin
        mean_q[i] <= (good_count == '0) ? '0 : div_quo[i];
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.mean_acc_x  = mean_q[0];
  assign out_ch.mean_acc_y  = mean_q[1];
  assign out_ch.mean_acc_z  = mean_q[2];
  assign out_ch.mean_rate_x = mean_q[3];
  assign out_ch.mean_rate_y = mean_q[4];
  assign out_ch.mean_rate_z = mean_q[5];
  assign out_ch.valid_count = count_q;

  // count never runs past the cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    good_count <= CNT_W'(CAP))
    else $error("valid count above cap");

  // an empty snapshot gives an all-zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    load_out && (good_count == '0) |=>
      (count_q == '0) && (mean_q[0] == '0) && (mean_q[1] == '0) &&
      (mean_q[2] == '0) && (mean_q[3] == '0) && (mean_q[4] == '0) &&
      (mean_q[5] == '0))
    else $error("empty snapshot gave nonzero result");

  // accumulators start the next snapshot from zero
  a_clear: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (good_count == '0) && (sums[0] == '0) && (sums[3] == '0))
    else $error("accumulators not cleared after result");

  // quotients are only taken once the divider has finished
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == gia_pkg::ST_OUT |-> !div_busy)
    else $error("result loaded while divider busy");

endmodule
